// File: hw/rtl/tgra_pkg.sv
// Shared types and constants for the tile grid rectangle allocator.
package tgra_pkg;

    // Register indexes of the configuration port
    localparam logic [0:0] REG_GRID_COLS = 1'b0;
    localparam logic [0:0] REG_GRID_ROWS = 1'b1;

    localparam int unsigned CFG_W    = 7;
    localparam int unsigned PIX_W    = 11;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned SIZE_W   = 7;
    localparam int unsigned SIZE_MAX = 127;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_WAIT   = 6'b000100,
        ST_TAKE   = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_CLEAR  = 6'b100000
    } t_state;

endpackage

// File: hw/rtl/tile_grid_rect_allocator_core.sv
// Top level: first-fit rectangle allocator over a row-organised tile occupancy bitmap.
// Sequence: each probed row is read, then checked; each taken row is read, checked, then
//   written; a result state and the strobe follow. A request that cannot fit by size goes
//   straight from acceptance to the result state.
// Throughput: one item at a time; busy falls in the strobe cycle. Results cannot be stalled.
// Reset: synchronous, active low; then a clearing pass over all MAX_ROWS rows with busy high.
module tile_grid_rect_allocator_core #(
    parameter int unsigned MAX_COLS    = 64,
    parameter int unsigned MAX_ROWS    = 64,
    parameter int unsigned TILE_PIXELS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [tgra_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [tgra_pkg::PIX_W-1:0]   i_pixel_width,
    input  logic [tgra_pkg::PIX_W-1:0]   i_pixel_height,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [tgra_pkg::POS_W-1:0]   o_tile_x,
    output logic [tgra_pkg::POS_W-1:0]   o_tile_y,
    output logic [tgra_pkg::SIZE_W-1:0]  o_tiles_wide,
    output logic [tgra_pkg::SIZE_W-1:0]  o_tiles_high
);

    localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // Count widths able to hold the limits themselves
    localparam int unsigned CCW = $clog2(MAX_COLS + 1) + 1;
    localparam int unsigned RCW = $clog2(MAX_ROWS + 1) + 1;
    localparam int unsigned TW  = tgra_pkg::PIX_W + 1;

    // Row memory: one word per tile row, bit c = column c, 1 = free
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rdata;
    logic [RW-1:0]       rd_addr;
    logic                wr_en;
    logic [RW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    tgra_pkg::t_state r_state, n_state;

    logic [tgra_pkg::CFG_W-1:0] r_grid_cols, r_grid_rows;
    logic [TW-1:0]  r_tw, r_th;
    logic [CCW-1:0] r_cols;
    logic [RCW-1:0] r_rows;
    logic [RW-1:0]  r_y;        // candidate top row
    logic [RCW-1:0] r_k;        // row offset within candidate
    logic [MAX_COLS-1:0] r_acc; // columns still viable as left edge
    logic [MAX_COLS-1:0] r_tmask;
    logic [CW-1:0]  r_x;
    logic           r_hit;

    // Rounded sizes and effective grid
    logic [TW-1:0]  tw_c, th_c;
    logic [CCW-1:0] cols_c;
    logic [RCW-1:0] rows_c;
    assign tw_c = TW'((TW'(i_pixel_width)  + TW'(TILE_PIXELS - 1)) / TILE_PIXELS);
    assign th_c = TW'((TW'(i_pixel_height) + TW'(TILE_PIXELS - 1)) / TILE_PIXELS);
    assign cols_c = (32'(r_grid_cols) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(r_grid_cols);
    assign rows_c = (32'(r_grid_rows) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(r_grid_rows);

    // Run-check unit: bit x set if columns x..x+tw-1 are free in the row word
    // and x+tw <= cols.
    logic [MAX_COLS-1:0] run_ok;
    always_comb begin
        logic [MAX_COLS-1:0] v;
        v = '0;
        for (int x = 0; x < MAX_COLS; x++) begin
            if (32'(x) + 32'(r_tw) <= 32'(r_cols)) begin
                v[x] = 1'b1;
            end
        end
        run_ok = v;
    end
    logic [MAX_COLS-1:0] row_fit;
    always_comb begin
        row_fit = '1;
        for (int x = 0; x < MAX_COLS; x++) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                if (c >= x && 32'(c) < 32'(x) + 32'(r_tw) && !r_rdata[c]) begin
                    row_fit[x] = 1'b0;
                end
            end
        end
        row_fit = row_fit & run_ok;
    end

    // Lowest set bit of the surviving candidates
    logic [CW-1:0] first_x;
    logic          any_x;
    always_comb begin
        first_x = '0;
        any_x   = 1'b0;
        for (int x = MAX_COLS - 1; x >= 0; x--) begin
            if (r_acc[x] & row_fit[x]) begin
                first_x = CW'(x);
                any_x   = 1'b1;
            end
        end
    end

    // Mask of the taken columns starting at r_x
    logic [MAX_COLS-1:0] take_mask;
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            take_mask[c] = (32'(c) >= 32'(r_x)) && (32'(c) < 32'(r_x) + 32'(r_tw));
        end
    end

    // Sequencer
    logic [RCW:0] last_k;
    logic         k_last;
    logic         y_last;
    assign last_k = (RCW+1)'(r_th) - 1'b1;
    assign k_last = ((RCW+1)'(r_k) == last_k);
    assign y_last = (32'(r_y) + 32'(r_th) + 1 > 32'(r_rows));
    always_comb begin
        n_state = r_state;
        rd_addr = RW'(32'(r_y) + 32'(r_k));
        wr_en   = 1'b0;
        wr_addr = RW'(32'(r_y) + 32'(r_k));
        wr_data = r_rdata & ~r_tmask;
        unique case (r_state)
            tgra_pkg::ST_IDLE: begin
                if (start) n_state = (tw_c != 0 && th_c != 0 && 32'(tw_c) <= 32'(cols_c)
                                      && 32'(th_c) <= 32'(rows_c))
                                     ? tgra_pkg::ST_WAIT : tgra_pkg::ST_RESULT;
            end
            tgra_pkg::ST_WAIT:   n_state = tgra_pkg::ST_CHECK;
            tgra_pkg::ST_CHECK: begin
                if (r_hit)                  n_state = tgra_pkg::ST_TAKE;
                else if (!any_x && y_last)  n_state = tgra_pkg::ST_RESULT;
                else                        n_state = tgra_pkg::ST_WAIT;
            end
            tgra_pkg::ST_TAKE: begin
                wr_en   = 1'b1;
                n_state = k_last ? tgra_pkg::ST_RESULT : tgra_pkg::ST_WAIT;
            end
            tgra_pkg::ST_RESULT: n_state = tgra_pkg::ST_IDLE;
            tgra_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_y;
                wr_data = '1;
                if (32'(r_y) == MAX_ROWS - 1) n_state = tgra_pkg::ST_IDLE;
            end
            default: n_state = tgra_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid     <= 1'b0;
            r_state     <= tgra_pkg::ST_CLEAR;
            r_grid_cols <= tgra_pkg::CFG_W'(64);
            r_grid_rows <= tgra_pkg::CFG_W'(64);
            r_y         <= '0;
            r_k         <= '0;
            r_hit       <= 1'b0;
        end else begin
            o_valid <= (r_state == tgra_pkg::ST_RESULT);
            if (i_cfg_we) begin
                if (i_cfg_index == tgra_pkg::REG_GRID_COLS) r_grid_cols <= i_cfg_data;
                else                                        r_grid_rows <= i_cfg_data;
            end
            r_state <= n_state;
            unique case (r_state)
                tgra_pkg::ST_CLEAR: begin
                    if (32'(r_y) == MAX_ROWS - 1) r_y <= '0;
                    else                          r_y <= r_y + 1'b1;
                end
                tgra_pkg::ST_IDLE: begin
                    r_tw   <= tw_c;
                    r_th   <= th_c;
                    r_cols <= cols_c;
                    r_rows <= rows_c;
                    r_y    <= '0;
                    r_k    <= '0;
                    r_acc  <= '1;
                    r_hit  <= 1'b0;
                    r_x    <= '0;
                end
                tgra_pkg::ST_WAIT: ;
                tgra_pkg::ST_CHECK: begin
                    if (r_hit) begin
                        // taking phase: current row read, write next cycle
                        r_tmask <= take_mask;
                    end else if (!any_x) begin
                        // no left edge survives: next candidate row
                        r_acc <= '1;
                        r_k   <= '0;
                        if (!y_last) r_y <= r_y + 1'b1;
                    end else if (k_last) begin
                        // all rows of the rectangle fit: first surviving column wins
                        r_hit   <= 1'b1;
                        r_x     <= first_x;
                        r_k     <= '0;
                    end else begin
                        r_acc <= r_acc & row_fit;
                        r_k   <= r_k + 1'b1;
                    end
                end
                tgra_pkg::ST_TAKE: begin
                    if (!k_last) r_k <= r_k + 1'b1;
                end
                tgra_pkg::ST_RESULT: ;
                default: ;
            endcase
        end
    end

    // Result fields held from the finished item
    always_comb begin
        o_found      = r_hit;
        o_tile_x     = r_hit ? tgra_pkg::POS_W'(r_x) : '0;
        o_tile_y     = r_hit ? tgra_pkg::POS_W'(r_y) : '0;
        o_tiles_wide = (32'(r_tw) > tgra_pkg::SIZE_MAX) ? tgra_pkg::SIZE_W'(tgra_pkg::SIZE_MAX)
                                                         : tgra_pkg::SIZE_W'(r_tw);
        o_tiles_high = (32'(r_th) > tgra_pkg::SIZE_MAX) ? tgra_pkg::SIZE_W'(tgra_pkg::SIZE_MAX)
                                                         : tgra_pkg::SIZE_W'(r_th);
    end

    assign busy = (r_state != tgra_pkg::ST_IDLE);

endmodule

// File: hw/rtl/tgra_checker.sv
// Port-level checker for the allocator, bound to the top level.
module tgra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_found,
    input logic [5:0] o_tile_x,
    input logic [5:0] o_tile_y,
    input logic [6:0] o_tiles_wide,
    input logic [6:0] o_tiles_high
);
    // An accepted item makes the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");
    // Result strobe lasts one cycle
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe too long");
    // Failure reports origin
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_tile_x == 0 && o_tile_y == 0))
        else $error("failed result with position");
    // Success needs a non-empty rectangle
    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_tiles_wide != 0 && o_tiles_high != 0))
        else $error("allocation of empty rectangle");
endmodule

bind tile_grid_rect_allocator_core tgra_checker u_tgra_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_found(o_found), .o_tile_x(o_tile_x), .o_tile_y(o_tile_y),
    .o_tiles_wide(o_tiles_wide), .o_tiles_high(o_tiles_high)
);

// File: test/tb_tile_grid_rect_allocator_core.sv
// Self-checking testbench for the tile grid rectangle allocator core.
`timescale 1ns / 100ps

module tb_tile_grid_rect_allocator_core;

    typedef enum logic [1:0] {K_REQ, K_CFG, K_DRAIN, K_IDLE} t_kind;

    typedef struct {
        t_kind                          kind;
        logic [tgra_pkg::PIX_W-1:0]     pix_w;
        logic [tgra_pkg::PIX_W-1:0]     pix_h;
        logic                           reg_idx;
        logic [tgra_pkg::CFG_W-1:0]     reg_val;
        int                             idle_pct;
    } t_entry;

    typedef struct packed {
        logic                           found;
        logic [tgra_pkg::POS_W-1:0]     tile_x;
        logic [tgra_pkg::POS_W-1:0]     tile_y;
        logic [tgra_pkg::SIZE_W-1:0]    tiles_wide;
        logic [tgra_pkg::SIZE_W-1:0]    tiles_high;
    } t_alloc;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_index = 1'b0;
    logic [tgra_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic [tgra_pkg::PIX_W-1:0]     i_pixel_width = '0;
    logic [tgra_pkg::PIX_W-1:0]     i_pixel_height = '0;
    logic                           o_valid;
    logic                           o_found;
    logic [tgra_pkg::POS_W-1:0]     o_tile_x;
    logic [tgra_pkg::POS_W-1:0]     o_tile_y;
    logic [tgra_pkg::SIZE_W-1:0]    o_tiles_wide;
    logic [tgra_pkg::SIZE_W-1:0]    o_tiles_high;

    t_entry  pending_items[$];
    t_alloc  expected_allocs[$];
    int      issued_cnt = 0;
    int      returned_cnt = 0;
    int      fail_cnt = 0;
    int      sender_idle_pct = 0;

    // Predictor state: occupancy map (1 = free) and grid registers
    bit          tile_free[64][64];
    logic [6:0]  grid_cols_reg = 7'd64;
    logic [6:0]  grid_rows_reg = 7'd64;

    tile_grid_rect_allocator_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // First-fit search over the predicted map; takes the tiles on a hit
    function automatic t_alloc allocate_rect(logic [tgra_pkg::PIX_W-1:0] pw,
                                             logic [tgra_pkg::PIX_W-1:0] ph);
        int     tw, th, cols, rows, x, y, r, c;
        bit     hit, clear;
        t_alloc a;
        tw   = (int'(pw) + 15) / 16;
        th   = (int'(ph) + 15) / 16;
        cols = grid_cols_reg > 64 ? 64 : int'(grid_cols_reg);
        rows = grid_rows_reg > 64 ? 64 : int'(grid_rows_reg);
        hit  = 1'b0;
        a    = '0;
        if (tw != 0 && th != 0 && tw <= cols && th <= rows) begin
            for (y = 0; y + th <= rows && !hit; y++) begin
                for (x = 0; x + tw <= cols && !hit; x++) begin
                    clear = 1'b1;
                    for (r = 0; r < th && clear; r++)
                        for (c = 0; c < tw && clear; c++)
                            if (!tile_free[y + r][x + c]) clear = 1'b0;
                    if (clear) begin
                        for (r = 0; r < th; r++)
                            for (c = 0; c < tw; c++)
                                tile_free[y + r][x + c] = 1'b0;
                        a.tile_x = x[tgra_pkg::POS_W-1:0];
                        a.tile_y = y[tgra_pkg::POS_W-1:0];
                        hit = 1'b1;
                    end
                end
            end
        end
        a.found      = hit;
        a.tiles_wide = tw > tgra_pkg::SIZE_MAX ? tgra_pkg::SIZE_W'(tgra_pkg::SIZE_MAX)
                                               : tw[tgra_pkg::SIZE_W-1:0];
        a.tiles_high = th > tgra_pkg::SIZE_MAX ? tgra_pkg::SIZE_W'(tgra_pkg::SIZE_MAX)
                                               : th[tgra_pkg::SIZE_W-1:0];
        return a;
    endfunction

    task automatic add_req(int w, int h);
        t_entry e;
        e = '{K_REQ, w[tgra_pkg::PIX_W-1:0], h[tgra_pkg::PIX_W-1:0], 1'b0, '0, 0};
        pending_items.push_back(e);
    endtask

    task automatic add_cfg(logic idx, int val);
        t_entry e;
        e = '{K_CFG, '0, '0, idx, val[tgra_pkg::CFG_W-1:0], 0};
        pending_items.push_back(e);
    endtask

    task automatic add_ctl(t_kind k, int pct);
        t_entry e;
        e = '{k, '0, '0, 1'b0, '0, pct};
        pending_items.push_back(e);
    endtask

    // Random grid size: mostly small, sometimes empty, large (up to full) or over range
    function automatic int pick_grid();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return 0;
        if (r < 18) return $urandom_range(127, 65);
        if (r < 35) return $urandom_range(64, 33);
        return $urandom_range(20, 1);
    endfunction

    // Driver: one item or register write per edge at most; a request is held until accepted
    always @(posedge i_clk) begin
        logic   took;
        logic   cfg_we_nxt;
        t_entry head;
        took       = start && !busy;
        cfg_we_nxt = 1'b0;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (took) begin
                expected_allocs.push_back(allocate_rect(i_pixel_width, i_pixel_height));
                issued_cnt <= issued_cnt + 1;
            end
            if (start && !took) begin
                // hold the item until accepted
            end else if (pending_items.size() == 0) begin
                start <= 1'b0;
            end else begin
                head = pending_items[0];
                case (head.kind)
                    K_IDLE: begin
                        sender_idle_pct = head.idle_pct;
                        void'(pending_items.pop_front());
                        start <= 1'b0;
                    end
                    K_DRAIN: begin
                        start <= 1'b0;
                        if (!took && !busy && issued_cnt == returned_cnt)
                            void'(pending_items.pop_front());
                    end
                    K_CFG: begin
                        start <= 1'b0;
                        if (!took && !busy && issued_cnt == returned_cnt) begin
                            cfg_we_nxt   = 1'b1;
                            i_cfg_index <= head.reg_idx;
                            i_cfg_data  <= head.reg_val;
                            if (head.reg_idx == tgra_pkg::REG_GRID_COLS)
                                grid_cols_reg = head.reg_val;
                            else
                                grid_rows_reg = head.reg_val;
                            void'(pending_items.pop_front());
                        end
                    end
                    default: begin
                        if ($urandom_range(99) < sender_idle_pct) begin
                            start <= 1'b0;
                        end else begin
                            start          <= 1'b1;
                            i_pixel_width  <= head.pix_w;
                            i_pixel_height <= head.pix_h;
                            void'(pending_items.pop_front());
                        end
                    end
                endcase
            end
            i_cfg_we <= cfg_we_nxt;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        t_alloc want;
        if (i_rst_n && o_valid) begin
            returned_cnt <= returned_cnt + 1;
            if (expected_allocs.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                want = expected_allocs.pop_front();
                if (o_found !== want.found || o_tile_x !== want.tile_x ||
                    o_tile_y !== want.tile_y || o_tiles_wide !== want.tiles_wide ||
                    o_tiles_high !== want.tiles_high) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch %0t: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 $realtime, want.found, want.tile_x, want.tile_y,
                                 want.tiles_wide, want.tiles_high, o_found, o_tile_x,
                                 o_tile_y, o_tiles_wide, o_tiles_high);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int p, s, n, w, h;
        int idle_plan[3];
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 64; c++)
                tile_free[r][c] = 1'b1;
        idle_plan = '{30, 77, 0};

        // directed: zero sizes, rounding, extremes, saturation, grid corners
        add_ctl(K_IDLE, 0);
        add_cfg(tgra_pkg::REG_GRID_COLS, 64);
        add_cfg(tgra_pkg::REG_GRID_ROWS, 64);
        add_req(0, 16);
        add_req(16, 0);
        add_req(0, 0);
        add_req(1, 1);
        add_req(16, 16);
        add_req(17, 33);
        add_req(1024, 16);
        add_req(1025, 16);
        add_req(2047, 2047);
        add_req(16, 1024);
        add_req(2047, 1);
        add_req(1024, 1024);
        add_cfg(tgra_pkg::REG_GRID_COLS, 0);
        add_req(16, 16);
        add_cfg(tgra_pkg::REG_GRID_COLS, 127);
        add_cfg(tgra_pkg::REG_GRID_ROWS, 100);
        add_req(32, 32);
        add_cfg(tgra_pkg::REG_GRID_COLS, 1);
        add_cfg(tgra_pkg::REG_GRID_ROWS, 1);
        add_req(1, 1);
        add_req(16, 16);
        add_cfg(tgra_pkg::REG_GRID_ROWS, 0);
        add_req(1, 1);
        add_ctl(K_DRAIN, 0);

        // random: three idling regimes, six grid settings each
        for (p = 0; p < 3; p++) begin
            add_ctl(K_IDLE, idle_plan[p]);
            for (s = 0; s < 6; s++) begin
                add_ctl(K_DRAIN, 0);
                add_cfg(tgra_pkg::REG_GRID_COLS, pick_grid());
                add_cfg(tgra_pkg::REG_GRID_ROWS, pick_grid());
                for (n = 0; n < 50; n++) begin
                    if ($urandom_range(9) == 0) begin
                        w = $urandom_range(2047);
                        h = $urandom_range(2047);
                    end else begin
                        w = $urandom_range(64);
                        h = $urandom_range(64);
                    end
                    add_req(w, h);
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || issued_cnt != returned_cnt)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0 && expected_allocs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
